FILE: rtl/s2trie_pkg.sv
// shared constants, word types and controller/datapath interface structs
package s2trie_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int HOP_WIDTH   = 16;
  localparam int KEY_WIDTH   = 32;

  localparam int KEY_FIELD_W = 32;
  localparam int HOP_FIELD_W = 16;
  localparam int LEN_W       = 6;

  localparam int IDX_W     = $clog2(NODE_COUNT);
  localparam int CNT_W     = $clog2(NODE_COUNT + 1);
  localparam int LEVELS    = (KEY_WIDTH + 1) / 2;
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int DIG_W     = $clog2(LEVELS);
  localparam int KEY_PAD_W = 2 * LEVELS;
  localparam int NEED_W    = $clog2(LEVELS + 3);

  typedef struct packed {
    logic                   func;
    logic [KEY_FIELD_W-1:0] key_bits;
    logic [LEN_W-1:0]       prefix_len;
    logic [HOP_FIELD_W-1:0] hop_in;
  } s2trie_in_t;

  typedef struct packed {
    logic                   found;
    logic [HOP_FIELD_W-1:0] hop_out;
    logic                   pool_full;
  } s2trie_out_t;

  typedef struct packed {
    logic [3:0][IDX_W-1:0] link;
    logic                  valid;
    logic                  native;
    logic [HOP_WIDTH-1:0]  hop;
  } s2trie_node_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic start;
    logic walk;
    logic check;
    logic build;
    logic exp_par;
    logic ch_start;
    logic ch_upd;
    logic finish;
  } s2trie_cmd_t;

  typedef struct packed {
    logic lookup;
    logic walk_done;
    logic pool_ok;
    logic at_full;
    logic odd;
    logic ch_new;
    logic k_last;
    logic out_free;
  } s2trie_status_t;

  // two key bits selecting the child at a given trie level
  function automatic logic [1:0] digit_at(input logic [KEY_PAD_W-1:0] key_pad,
                                          input logic [DIG_W-1:0] level);
    logic [1:0] d;
    d = 2'b00;
    for (int i = 0; i < LEVELS; i++) begin
      if (level == DIG_W'(i)) begin
        d = key_pad[KEY_PAD_W-1-2*i -: 2];
      end
    end
    return d;
  endfunction

endpackage

FILE: rtl/s2trie_ctrl.sv
// sequencing state machine for lookup and insert
module s2trie_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  output s2trie_pkg::s2trie_cmd_t    cmd,
  input  s2trie_pkg::s2trie_status_t status
);
  import s2trie_pkg::*;

  typedef enum logic [9:0] {
    S_CLR     = 10'b00_0000_0001,
    S_IDLE    = 10'b00_0000_0010,
    S_START   = 10'b00_0000_0100,
    S_WALK    = 10'b00_0000_1000,
    S_CHECK   = 10'b00_0001_0000,
    S_BUILD   = 10'b00_0010_0000,
    S_EXPAR   = 10'b00_0100_0000,
    S_CHSTART = 10'b00_1000_0000,
    S_CHUPD   = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = status.lookup ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = status.pool_ok ? S_BUILD : S_DONE;
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        if (status.at_full) begin
          state_nxt = status.odd ? S_EXPAR : S_DONE;
        end
      end
      S_EXPAR: begin
        cmd.exp_par = 1'b1;
        state_nxt   = S_CHSTART;
      end
      S_CHSTART: begin
        cmd.ch_start = 1'b1;
        if (!status.ch_new) begin
          state_nxt = S_CHUPD;
        end else if (status.k_last) begin
          state_nxt = S_DONE;
        end
      end
      S_CHUPD: begin
        cmd.ch_upd = 1'b1;
        state_nxt  = status.k_last ? S_DONE : S_CHSTART;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: rtl/s2trie_dp.sv
// node memory, trie walk registers, allocation counter and result register
module s2trie_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  s2trie_pkg::s2trie_cmd_t    cmd,
  output s2trie_pkg::s2trie_status_t status,
  input  s2trie_pkg::s2trie_in_t     in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output s2trie_pkg::s2trie_out_t    out_data
);
  import s2trie_pkg::*;

  s2trie_node_t           node_mem_r [NODE_COUNT];
  s2trie_node_t           mem_q_r;

  logic                   func_r;
  logic [KEY_PAD_W-1:0]   key_pad_r;
  logic [LVL_W-1:0]       full_r;
  logic                   odd_r;
  logic [HOP_WIDTH-1:0]   hop_r;
  logic [LVL_W-1:0]       level_r;
  logic [IDX_W-1:0]       node_r;
  s2trie_node_t           cur_word_r;
  logic [CNT_W-1:0]       nodes_used_r;
  logic [NEED_W-1:0]      need_r;
  logic                   found_r;
  logic [HOP_WIDTH-1:0]   best_r;
  logic                   pool_full_r;
  logic [IDX_W-1:0]       ch0_r;
  logic [IDX_W-1:0]       ch1_r;
  logic [1:0]             new_r;
  logic                   k_r;
  logic                   out_valid_r;
  s2trie_out_t            out_data_r;

  logic [1:0]             digit;
  logic [IDX_W-1:0]       walk_link;
  logic                   below_full;
  logic                   walk_cont;
  logic [1:0]             slot0;
  logic [1:0]             slot1;
  logic [NEED_W-1:0]      need_calc;
  logic [CNT_W-1:0]       free_nodes;
  logic                   pool_ok;
  logic [IDX_W-1:0]       new_idx;
  logic [IDX_W-1:0]       c0;
  logic [IDX_W-1:0]       c1;
  logic                   e0;
  logic                   e1;
  logic [IDX_W-1:0]       n1;
  logic [IDX_W-1:0]       ch_cur;
  logic                   ch_is_new;
  logic                   out_free;
  logic [LEN_W-1:0]       len_sat;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  s2trie_node_t           mem_wd;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_ra;

  assign digit      = digit_at(key_pad_r, level_r[DIG_W-1:0]);
  assign walk_link  = mem_q_r.link[digit];
  assign below_full = (level_r < full_r);
  assign walk_cont  = func_r ? ((level_r < LVL_W'(LEVELS)) && (walk_link != '0))
                             : (below_full && (walk_link != '0));

  // odd prefix: last bit picks the pair of children (b,0) and (b,1)
  assign slot0 = {digit[1], 1'b0};
  assign slot1 = {digit[1], 1'b1};

  always_comb begin
    if (below_full) begin
      need_calc = NEED_W'(full_r - level_r) + (odd_r ? NEED_W'(2) : NEED_W'(0));
    end else if (odd_r) begin
      need_calc = NEED_W'(mem_q_r.link[slot0] == '0) + NEED_W'(mem_q_r.link[slot1] == '0);
    end else begin
      need_calc = '0;
    end
  end

  assign free_nodes = CNT_W'(NODE_COUNT) - nodes_used_r;
  assign pool_ok    = (CNT_W'(need_r) <= free_nodes);
  assign new_idx    = nodes_used_r[IDX_W-1:0];

  assign c0 = cur_word_r.link[slot0];
  assign c1 = cur_word_r.link[slot1];
  assign e0 = (c0 == '0);
  assign e1 = (c1 == '0);
  assign n1 = new_idx + IDX_W'(e0);

  assign ch_cur    = k_r ? ch1_r : ch0_r;
  assign ch_is_new = new_r[k_r];
  assign out_free  = !out_valid_r || !out_stall;

  assign len_sat = (in_data.prefix_len > LEN_W'(KEY_WIDTH)) ? LEN_W'(KEY_WIDTH)
                                                           : in_data.prefix_len;

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = node_r;
    mem_wd = cur_word_r;
    mem_re = 1'b0;
    mem_ra = '0;
    if (cmd.clr) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = '0;
    end
    if (cmd.start) begin
      mem_re = 1'b1;
      mem_ra = '0;
    end
    if (cmd.walk) begin
      mem_re = walk_cont;
      mem_ra = walk_link;
    end
    if (cmd.build) begin
      mem_we = below_full || !odd_r;
      mem_wd = cur_word_r;
      if (below_full) begin
        mem_wd.link[digit] = new_idx;
      end else begin
        mem_wd.valid  = 1'b1;
        mem_wd.native = 1'b1;
        mem_wd.hop    = hop_r;
      end
    end
    if (cmd.exp_par) begin
      mem_we = 1'b1;
      mem_wd = cur_word_r;
      if (e0) begin
        mem_wd.link[slot0] = new_idx;
      end
      if (e1) begin
        mem_wd.link[slot1] = n1;
      end
    end
    if (cmd.ch_start) begin
      if (ch_is_new) begin
        mem_we       = 1'b1;
        mem_wa       = ch_cur;
        mem_wd       = '0;
        mem_wd.valid = 1'b1;
        mem_wd.hop   = hop_r;
      end else begin
        mem_re = 1'b1;
        mem_ra = ch_cur;
      end
    end
    if (cmd.ch_upd) begin
      // an expanded hop never replaces a native one
      mem_we       = !mem_q_r.native;
      mem_wa       = ch_cur;
      mem_wd       = mem_q_r;
      mem_wd.valid = 1'b1;
      mem_wd.hop   = hop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= node_mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_used_r <= CNT_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.build && below_full) begin
        nodes_used_r <= nodes_used_r + CNT_W'(1);
      end else if (cmd.exp_par) begin
        nodes_used_r <= nodes_used_r + CNT_W'(e0) + CNT_W'(e1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r      <= in_data.func;
      key_pad_r   <= KEY_PAD_W'(in_data.key_bits[KEY_WIDTH-1:0]) << (KEY_PAD_W - KEY_WIDTH);
      full_r      <= LVL_W'(len_sat >> 1);
      odd_r       <= len_sat[0];
      hop_r       <= in_data.hop_in[HOP_WIDTH-1:0];
      found_r     <= 1'b0;
      best_r      <= '0;
      pool_full_r <= 1'b0;
      level_r     <= '0;
      node_r      <= '0;
    end
    if (cmd.walk) begin
      if (func_r && mem_q_r.valid) begin
        found_r <= 1'b1;
        best_r  <= mem_q_r.hop;
      end
      if (walk_cont) begin
        node_r  <= walk_link;
        level_r <= level_r + LVL_W'(1);
      end else begin
        cur_word_r <= mem_q_r;
        need_r     <= need_calc;
      end
    end
    if (cmd.check && !pool_ok) begin
      pool_full_r <= 1'b1;
    end
    if (cmd.build && below_full) begin
      node_r     <= new_idx;
      cur_word_r <= '0;
      level_r    <= level_r + LVL_W'(1);
    end
    if (cmd.exp_par) begin
      ch0_r <= e0 ? new_idx : c0;
      ch1_r <= e1 ? n1 : c1;
      new_r <= {e1, e0};
      k_r   <= 1'b0;
    end
    if ((cmd.ch_start && ch_is_new) || cmd.ch_upd) begin
      k_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_data_r.found     <= found_r;
      out_data_r.hop_out   <= found_r ? HOP_FIELD_W'(best_r) : '0;
      out_data_r.pool_full <= pool_full_r;
    end
  end

  assign status.lookup    = func_r;
  assign status.walk_done = !walk_cont;
  assign status.pool_ok   = pool_ok;
  assign status.at_full   = !below_full;
  assign status.odd       = odd_r;
  assign status.ch_new    = ch_is_new;
  assign status.k_last    = k_r;
  assign status.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r != '0) && (nodes_used_r <= CNT_W'(NODE_COUNT)))
    else $error("node allocation count out of range");

  a_write_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CNT_W'(mem_wa) < nodes_used_r))
    else $error("write to a node that was never allocated");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> out_free)
    else $error("result loaded over an undelivered word");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.found && out_data_r.pool_full))
    else $error("result flags both a match and a full pool");

  a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk |-> (level_r <= LVL_W'(LEVELS)))
    else $error("trie walk past the last level");

endmodule

FILE: rtl/stride2_trie_prefix_lookup_core.sv
// Longest-prefix-match engine over a 4-ary trie held in a 4096-node memory.
// One word is handled at a time. A lookup reads one node per trie level, down to
// at most 16 levels below the root. An insert walks the existing path the same
// way, checks that the pool has enough free nodes, then writes one link for
// each node it creates and then the hop; for an odd-length prefix the hop goes
// into the two expanded children instead. After reset the root node is cleared
// before the first word is taken; every other node is cleared when it is
// allocated.
module stride2_trie_prefix_lookup_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  s2trie_pkg::s2trie_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output s2trie_pkg::s2trie_out_t out_data
);
  import s2trie_pkg::*;

  s2trie_cmd_t    cmd;
  s2trie_status_t status;

  s2trie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  s2trie_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the stride-2 trie longest-prefix-match core
module tb;
  import s2trie_pkg::*;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;
  localparam int   QUIET_LIMIT = 5000;
  localparam int   DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  s2trie_in_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  s2trie_out_t out_data;

  int snd_idle_pct = 24;
  int rcv_idle_pct = 77;
  int err_count = 0;
  int quiet_cycles = 0;

  // shadow copy of the trie
  int unsigned          child_of [NODE_COUNT][4];
  bit                   route_valid [NODE_COUNT];
  bit                   route_native [NODE_COUNT];
  bit [HOP_WIDTH-1:0]   route_hop [NODE_COUNT];
  int unsigned          nodes_alloc = 1;

  s2trie_out_t          pending_routes [$];
  bit [KEY_FIELD_W-1:0] stored_keys [$];
  s2trie_out_t          want;

  stride2_trie_prefix_lookup_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit key_bit(input bit [KEY_FIELD_W-1:0] key, input int unsigned pos);
    if (pos >= KEY_WIDTH) return 1'b0;
    return key[KEY_WIDTH-1-pos];
  endfunction

  function automatic bit [1:0] key_digit(input bit [KEY_FIELD_W-1:0] key,
                                         input int unsigned level);
    return {key_bit(key, 2 * level), key_bit(key, 2 * level + 1)};
  endfunction

  // nodes an insert would have to allocate
  function automatic int unsigned nodes_needed(input bit [KEY_FIELD_W-1:0] key,
                                               input int unsigned len);
    int unsigned need, n, l, k;
    bit missing;
    need = 0;
    n = 0;
    missing = 1'b0;
    for (l = 0; l < len / 2; l++) begin
      if (missing) begin
        need++;
      end else if (child_of[n][key_digit(key, l)] == 0) begin
        missing = 1'b1;
        need++;
      end else begin
        n = child_of[n][key_digit(key, l)];
      end
    end
    if (len % 2 == 1) begin
      if (missing) begin
        need += 2;
      end else begin
        for (k = 0; k < 2; k++) begin
          if (child_of[n][{key_bit(key, len - 1), k[0]}] == 0) need++;
        end
      end
    end
    return need;
  endfunction

  function automatic int unsigned grab_child(input int unsigned n, input bit [1:0] idx);
    int unsigned c;
    c = child_of[n][idx];
    if (c == 0) begin
      c = nodes_alloc;
      nodes_alloc++;
      child_of[c] = '{0, 0, 0, 0};
      route_valid[c] = 1'b0;
      route_native[c] = 1'b0;
      route_hop[c] = '0;
      child_of[n][idx] = c;
    end
    return c;
  endfunction

  function automatic bit insert_route(input bit [KEY_FIELD_W-1:0] key, input int unsigned len,
                                      input bit [HOP_WIDTH-1:0] hop);
    int unsigned n, l, k, c;
    if (len > KEY_WIDTH) len = KEY_WIDTH;
    if (nodes_needed(key, len) > NODE_COUNT - nodes_alloc) return 1'b0;
    n = 0;
    for (l = 0; l < len / 2; l++) n = grab_child(n, key_digit(key, l));
    if (len % 2 == 0) begin
      route_valid[n] = 1'b1;
      route_native[n] = 1'b1;
      route_hop[n] = hop;
    end else begin
      // odd length: the last bit picks both children, never over a native hop
      for (k = 0; k < 2; k++) begin
        c = grab_child(n, {key_bit(key, len - 1), k[0]});
        if (!route_native[c]) begin
          route_valid[c] = 1'b1;
          route_hop[c] = hop;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic s2trie_out_t predict_route(input s2trie_in_t w);
    s2trie_out_t r;
    int unsigned n, l, c;
    r = '0;
    if (w.func == FUNC_INSERT) begin
      r.pool_full = !insert_route(w.key_bits, 32'(w.prefix_len), w.hop_in);
    end else begin
      r.found = route_valid[0];
      r.hop_out = route_hop[0];
      n = 0;
      for (l = 0; l < LEVELS; l++) begin
        c = child_of[n][key_digit(w.key_bits, l)];
        if (c == 0 || c >= NODE_COUNT) break;
        n = c;
        if (route_valid[n]) begin
          r.found = 1'b1;
          r.hop_out = route_hop[n];
        end
      end
      if (!r.found) r.hop_out = '0;
    end
    return r;
  endfunction

  task automatic send_word(input logic f, input bit [KEY_FIELD_W-1:0] key,
                           input int unsigned len, input bit [HOP_FIELD_W-1:0] hop);
    s2trie_in_t w;
    w.func = f;
    w.key_bits = key;
    w.prefix_len = LEN_W'(len);
    w.hop_in = hop;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pending_routes.push_back(predict_route(w));
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    err_count++;
    if (err_count <= 100)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, exp_val);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("unexpected result word", 32'(out_data), 32'h0);
      end else begin
        want = pending_routes.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", 32'(out_data.found), 32'(want.found));
        if (out_data.hop_out !== want.hop_out)
          report_mismatch("hop_out", 32'(out_data.hop_out), 32'(want.hop_out));
        if (out_data.pool_full !== want.pool_full)
          report_mismatch("pool_full", 32'(out_data.pool_full), 32'(want.pool_full));
      end
    end
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL stride2_trie_prefix_lookup_core");
      $finish;
    end
  end

  task automatic test_directed;
    // empty trie
    send_word(FUNC_LOOKUP, 32'h0000_0000, 0, 16'h0000);
    send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 63, 16'hFFFF);
    send_word(FUNC_INSERT, 32'hFFFF_FFFF, 32, 16'h1234);
    send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 0, 16'h0000);
    send_word(FUNC_LOOKUP, 32'hFFFF_FFFE, 0, 16'h0000);
    // one-bit prefix lands in two root children
    send_word(FUNC_INSERT, 32'h8000_0000, 1, 16'hAAAA);
    send_word(FUNC_LOOKUP, 32'h8000_0000, 0, 16'h0000);
    send_word(FUNC_LOOKUP, 32'hFFFF_FFFE, 0, 16'h0000);
    // native over expanded, then expanded must not touch the native one
    send_word(FUNC_INSERT, 32'hC000_0000, 2, 16'h5555);
    send_word(FUNC_INSERT, 32'hFFFF_FFFF, 1, 16'h7777);
    send_word(FUNC_LOOKUP, 32'hC000_0000, 0, 16'h0000);
    send_word(FUNC_LOOKUP, 32'hA000_0000, 0, 16'h0000);
    // native re-insert overwrites
    send_word(FUNC_INSERT, 32'hFFFF_FFFF, 32, 16'hFFFF);
    send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 0, 16'h0000);
    // over-long prefix lengths saturate
    send_word(FUNC_INSERT, 32'h0000_0001, 63, 16'h0001);
    send_word(FUNC_LOOKUP, 32'h0000_0001, 0, 16'h0000);
    send_word(FUNC_INSERT, 32'h0000_0000, 33, 16'h0002);
    send_word(FUNC_LOOKUP, 32'h0000_0000, 0, 16'h0000);
    // odd length at the bottom of the trie
    send_word(FUNC_INSERT, 32'h1234_5678, 31, 16'h3C3C);
    send_word(FUNC_LOOKUP, 32'h1234_5679, 0, 16'h0000);
    send_word(FUNC_LOOKUP, 32'h1234_567A, 0, 16'h0000);
    // default route, then again with junk key bits
    send_word(FUNC_INSERT, 32'h0000_0000, 0, 16'h0000);
    send_word(FUNC_LOOKUP, 32'h5555_5555, 0, 16'h0000);
    send_word(FUNC_INSERT, 32'hFFFF_FFFF, 0, 16'hBEEF);
    send_word(FUNC_LOOKUP, 32'h5555_5555, 0, 16'h0000);
  endtask

  task automatic test_random_routes(input int count);
    bit [KEY_FIELD_W-1:0] base, keep, key;
    bit [HOP_FIELD_W-1:0] hop;
    int unsigned len;
    repeat (count) begin
      if (stored_keys.size() > 0 && $urandom_range(3) != 0)
        base = stored_keys[$urandom_range(stored_keys.size() - 1)];
      else
        base = $urandom;
      keep = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
      key = (base & keep) | ($urandom & ~keep);
      case ($urandom_range(9))
        0:       hop = 16'hFFFF;
        1:       hop = 16'h0000;
        default: hop = 16'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(33, 63);
          1, 2:    len = $urandom_range(0, 8);
          default: len = $urandom_range(0, 32);
        endcase
        send_word(FUNC_INSERT, key, len, hop);
        stored_keys.push_back(key);
      end else begin
        send_word(FUNC_LOOKUP, key, $urandom_range(0, 63), hop);
      end
    end
  endtask

  task automatic test_pool_exhaustion;
    bit [KEY_FIELD_W-1:0] key;
    // deep inserts until only a handful of nodes are free
    while (NODE_COUNT - nodes_alloc > 24) begin
      key = $urandom;
      send_word(FUNC_INSERT, key, 32, 16'($urandom_range(0, 65535)));
      stored_keys.push_back(key);
    end
    // mix of refused, fitting and path-only inserts and lookups around the full point
    repeat (40) begin
      case ($urandom_range(4))
        0, 1: send_word(FUNC_INSERT, $urandom, $urandom_range(1, 32),
                        16'($urandom_range(0, 65535)));
        2:    send_word(FUNC_INSERT, stored_keys[$urandom_range(stored_keys.size() - 1)],
                        32, 16'($urandom_range(0, 65535)));
        default: send_word(FUNC_LOOKUP, stored_keys[$urandom_range(stored_keys.size() - 1)],
                           0, 16'h0000);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 24;
    rcv_idle_pct = 77;
    test_directed();
    test_random_routes(80);

    snd_idle_pct = 77;
    rcv_idle_pct = 24;
    test_random_routes(80);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_pool_exhaustion();

    in_valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("PASS stride2_trie_prefix_lookup_core");
    else
      $display("FAIL stride2_trie_prefix_lookup_core");
    $finish;
  end

endmodule

FILE: stride2_trie_prefix_lookup_core.f
rtl/s2trie_pkg.sv
rtl/s2trie_ctrl.sv
rtl/s2trie_dp.sv
rtl/stride2_trie_prefix_lookup_core.sv
tb/sv/tb.sv
